// ----- src/nir_pkg.sv -----
// Shared types and constants for the pulse-distance IR frame transmitter.
// No dependencies; imported by the core.
package nir_pkg;

    localparam int UNIT_W   = 16;
    localparam int FRAME_W  = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TICKS = 1'b1;

    localparam logic [UNIT_W-1:0]  UNIT_TICKS_RST  = 16'd562;
    localparam logic [FRAME_W-1:0] FRAME_TICKS_RST = 20'd108000;

    localparam logic [FRAME_W-1:0] ELAPSED_MAX = {FRAME_W{1'b1}};

    localparam int BITS_PER_BYTE = 8;

    // input beat action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_LEAD_MARK  = 8'b0000_0010,
        PH_LEAD_SPACE = 8'b0000_0100,
        PH_BIT_MARK   = 8'b0000_1000,
        PH_BIT_SPACE  = 8'b0001_0000,
        PH_END_MARK   = 8'b0010_0000,
        PH_END_SPACE  = 8'b0100_0000,
        PH_GAP        = 8'b1000_0000
    } phase_t;

endpackage

// ----- src/nir_channels.sv -----
// Valid/ready channel interfaces for the IR frame transmitter.
// Depends on nothing; used by the core top level.
interface nir_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, action, data_byte, last_byte, input ready);
    modport sink   (input valid, action, data_byte, last_byte, output ready);
endinterface

interface nir_out_if;
    logic valid;
    logic ready;
    logic led_on;
    logic busy_res;
    logic frame_done;
    logic rejected;

    modport source (output valid, led_on, busy_res, frame_done, rejected, input ready);
    modport sink   (input valid, led_on, busy_res, frame_done, rejected, output ready);
endinterface

// ----- src/nec_ir_frame_transmitter_core.sv -----
// Pulse-distance IR frame transmitter core: byte buffer, segment timer, result register.
// Depends on nir_pkg and the channel interfaces in nir_channels.sv.
//
// Each input beat is either a time tick or a byte load and yields exactly one result
// beat in the following cycle. The whole update (segment countdown, phase step, elapsed count)
// is a single pass of logic from the state registers into the result register, so a
// new beat is taken every cycle; the only thing that holds input is a full result
// register whose beat the sink has not taken. Loads fill a buffer of MAX_BYTES bytes;
// the byte flagged last starts a frame: leader of 16 units mark, 8 units space, then
// each byte MSB first (one = 1 mark + 3 space, zero = 1 mark + 1 space), an end bit,
// and an off gap up to frame_ticks measured from leader start. Loads during a frame
// are rejected. Configuration is written through cfg_we/cfg_index/cfg_data.
module nec_ir_frame_transmitter_core
    import nir_pkg::*;
#(
    parameter int MAX_BYTES = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    nir_in_if.sink                items,
    nir_out_if.source             results
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);
    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);

    logic [UNIT_W-1:0]  unit_ticks_reg;
    logic [FRAME_W-1:0] frame_ticks_reg;

    logic [7:0]         byte_store [MAX_BYTES];
    logic [CNT_W-1:0]   bytes_loaded_reg, bytes_loaded_next;
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [2:0]         bit_pos_reg, bit_pos_next;
    logic [FRAME_W-1:0] seg_rem_reg, seg_rem_next;
    logic [FRAME_W-1:0] elapsed_reg, elapsed_next;

    logic out_valid_reg, out_valid_next;
    logic led_reg, busy_reg, done_reg, rej_reg;
    logic led_next, busy_next, done_next, rej_next;

    logic               accept;
    logic               store_we;
    logic [FRAME_W-1:0] seg1, seg3, seg8, seg16;
    logic [FRAME_W-1:0] seg_dec;
    logic [7:0]         cur_byte;
    logic               cur_bit;
    logic [3:0]         bit_inc;
    logic [CNT_W-1:0]   byte_inc;

    assign items.ready = !out_valid_reg || results.ready;
    assign accept      = items.valid && items.ready;

    assign seg1  = FRAME_W'(unit_ticks_reg);
    assign seg3  = FRAME_W'({unit_ticks_reg, 1'b0}) + FRAME_W'(unit_ticks_reg);
    assign seg8  = FRAME_W'({unit_ticks_reg, 3'b000});
    assign seg16 = FRAME_W'({unit_ticks_reg, 4'b0000});

    // byte_pos is below bytes_loaded whenever a bit mark is in progress
    assign cur_byte = byte_store[byte_pos_reg[IDX_W-1:0]];
    assign cur_bit  = cur_byte[3'd7 - bit_pos_reg];
    assign bit_inc  = {1'b0, bit_pos_reg} + 4'd1;
    assign byte_inc = byte_pos_reg + CNT_W'(1);
    assign seg_dec  = (seg_rem_reg != '0) ? seg_rem_reg - FRAME_W'(1) : '0;

    always_comb
    begin
        bytes_loaded_next = bytes_loaded_reg;
        phase_next        = phase_reg;
        byte_pos_next     = byte_pos_reg;
        bit_pos_next      = bit_pos_reg;
        seg_rem_next      = seg_rem_reg;
        elapsed_next      = elapsed_reg;
        store_we          = 1'b0;
        led_next          = 1'b0;
        busy_next         = 1'b0;
        done_next         = 1'b0;
        rej_next          = 1'b0;

        if (items.action == ACT_LOAD)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej_next  = 1'b1;
                busy_next = 1'b1;
            end
            else if (bytes_loaded_reg >= CNT_MAX)
            begin
                // full: drop the byte; a last flag empties the buffer
                rej_next = 1'b1;
                if (items.last_byte)
                    bytes_loaded_next = '0;
            end
            else
            begin
                store_we          = 1'b1;
                bytes_loaded_next = bytes_loaded_reg + CNT_W'(1);
                if (items.last_byte)
                begin
                    phase_next    = PH_LEAD_MARK;
                    seg_rem_next  = seg16;
                    elapsed_next  = '0;
                    byte_pos_next = '0;
                    bit_pos_next  = '0;
                    busy_next     = 1'b1;
                end
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            busy_next    = 1'b1;
            led_next     = (phase_reg == PH_LEAD_MARK) || (phase_reg == PH_BIT_MARK) ||
                           (phase_reg == PH_END_MARK);
            elapsed_next = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + FRAME_W'(1)
                                                        : elapsed_reg;
            seg_rem_next = seg_dec;
            if (seg_dec == '0)
            begin
                case (phase_reg)
                    PH_LEAD_MARK:
                    begin
                        phase_next   = PH_LEAD_SPACE;
                        seg_rem_next = seg8;
                    end
                    PH_LEAD_SPACE:
                    begin
                        byte_pos_next = '0;
                        bit_pos_next  = '0;
                        phase_next    = (bytes_loaded_reg != '0) ? PH_BIT_MARK : PH_END_MARK;
                        seg_rem_next  = seg1;
                    end
                    PH_BIT_MARK:
                    begin
                        phase_next   = PH_BIT_SPACE;
                        seg_rem_next = cur_bit ? seg3 : seg1;
                    end
                    PH_BIT_SPACE:
                    begin
                        seg_rem_next = seg1;
                        if (bit_inc == 4'(BITS_PER_BYTE))
                        begin
                            bit_pos_next  = '0;
                            byte_pos_next = byte_inc;
                            phase_next    = (byte_inc >= bytes_loaded_reg) ? PH_END_MARK
                                                                           : PH_BIT_MARK;
                        end
                        else
                        begin
                            bit_pos_next = bit_inc[2:0];
                            phase_next   = (byte_pos_reg >= bytes_loaded_reg) ? PH_END_MARK
                                                                              : PH_BIT_MARK;
                        end
                    end
                    PH_END_MARK:
                    begin
                        phase_next   = PH_END_SPACE;
                        seg_rem_next = seg1;
                    end
                    PH_END_SPACE:
                    begin
                        if (elapsed_next < frame_ticks_reg)
                        begin
                            phase_next   = PH_GAP;
                            seg_rem_next = frame_ticks_reg - elapsed_next;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
                if (done_next)
                begin
                    phase_next        = PH_IDLE;
                    seg_rem_next      = '0;
                    bytes_loaded_next = '0;
                    byte_pos_next     = '0;
                    bit_pos_next      = '0;
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg  <= UNIT_TICKS_RST;
            frame_ticks_reg <= FRAME_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UNIT_TICKS:  unit_ticks_reg  <= cfg_data[UNIT_W-1:0];
                REG_FRAME_TICKS: frame_ticks_reg <= cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_loaded_reg <= '0;
            phase_reg        <= PH_IDLE;
            byte_pos_reg     <= '0;
            bit_pos_reg      <= '0;
            seg_rem_reg      <= '0;
            elapsed_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                bytes_loaded_reg <= bytes_loaded_next;
                phase_reg        <= phase_next;
                byte_pos_reg     <= byte_pos_next;
                bit_pos_reg      <= bit_pos_next;
                seg_rem_reg      <= seg_rem_next;
                elapsed_reg      <= elapsed_next;
            end
        end
    end

    // payload only: buffer and result beat
    always_ff @(posedge clk)
    begin
        if (accept && store_we)
            byte_store[bytes_loaded_reg[IDX_W-1:0]] <= items.data_byte;
        if (accept)
        begin
            led_reg  <= led_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            rej_reg  <= rej_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.led_on     = led_reg;
    assign results.busy_res   = busy_reg;
    assign results.frame_done = done_reg;
    assign results.rejected   = rej_reg;

endmodule

// ----- src/nir_checker.sv -----
// Port-level assertions for the IR frame transmitter core, attached by bind.
// Depends on nec_ir_frame_transmitter_core and its channel interfaces.
module nir_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic led_on,
    input logic busy_res,
    input logic frame_done,
    input logic rejected
);

    // end of frame is always reported as part of the frame
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> busy_res)
        else $error("frame_done without busy_res");

    // LED mark only during a frame
    a_led_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && led_on |-> busy_res && !rejected && !frame_done)
        else $error("led_on outside a frame");

    // a rejected beat is a load: no tick outputs
    a_rej_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> !led_on && !frame_done)
        else $error("rejected beat carries tick outputs");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(led_on) && $stable(busy_res) &&
                                    $stable(frame_done) && $stable(rejected))
        else $error("result beat changed while stalled");

endmodule

bind nec_ir_frame_transmitter_core nir_checker u_nir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .led_on     (results.led_on),
    .busy_res   (results.busy_res),
    .frame_done (results.frame_done),
    .rejected   (results.rejected)
);
